/* hdl/slce_pkg.sv */
// Package for the serial command line editor.
// Holds byte codes, payload widths, the default line capacity and the store write type.
// No dependencies.
package slce_pkg;

  localparam int BYTE_W = 8;
  localparam int LINE_CAPACITY_DEF = 32;

  localparam logic [BYTE_W-1:0] CH_ESC = 8'h1b;
  localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5b;
  localparam logic [BYTE_W-1:0] CH_UP = 8'h41;
  localparam logic [BYTE_W-1:0] CH_DOWN = 8'h42;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_SEEN = 2'd1,
    ESC_BRACKET = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic we;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

endpackage

/* hdl/slce_chan_if.sv */
// Valid/ready channel interfaces for received bytes and emitted bytes.
// Depends on slce_pkg for payload widths.
interface slce_rx_if;
  import slce_pkg::*;
  logic valid;
  logic ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slce_tx_if;
  import slce_pkg::*;
  logic valid;
  logic ready;
  logic out_kind;
  logic [BYTE_W-1:0] out_byte;
  logic run_last;
  modport source (output valid, output out_kind, output out_byte, output run_last,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input run_last,
                output ready);
endinterface

/* hdl/slce_line_store.sv */
// Line store memory: one write port, one registered read port.
// Depends on slce_pkg.
module slce_line_store #(
  parameter int LINE_CAPACITY = slce_pkg::LINE_CAPACITY_DEF,
  localparam int AW = $clog2(LINE_CAPACITY)
) (
  input  logic                     clk,
  input  slce_pkg::store_wr_t      wr,
  input  logic [AW-1:0]            waddr,
  input  logic [AW-1:0]            raddr,
  output logic [slce_pkg::BYTE_W-1:0] rd_data
);
  import slce_pkg::*;

  logic [BYTE_W-1:0] mem [LINE_CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
    rd_data <= mem[raddr];
  end

endmodule

/* hdl/slce_ctrl.sv */
// Editing sequencer: escape tracker, fill and line-length counters, read pointer
// and the output register. Depends on slce_pkg; drives slce_line_store.
module slce_ctrl #(
  parameter int LINE_CAPACITY = slce_pkg::LINE_CAPACITY_DEF,
  localparam int AW = $clog2(LINE_CAPACITY)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        echo_enable,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [slce_pkg::BYTE_W-1:0] in_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [slce_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last,
  output slce_pkg::store_wr_t         wr,
  output logic [AW-1:0]               waddr,
  output logic [AW-1:0]               raddr,
  input  logic [slce_pkg::BYTE_W-1:0] rd_data
);
  import slce_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_BS1   = 9'b000000010,
    S_BS2   = 9'b000000100,
    S_BS3   = 9'b000001000,
    S_LF    = 9'b000010000,
    S_CR    = 9'b000100000,
    S_FETCH = 9'b001000000,
    S_SEND  = 9'b010000000,
    S_ECHO  = 9'b100000000
  } state_t;

  localparam logic [AW-1:0] FILL_MAX = AW'(LINE_CAPACITY - 1);
  localparam logic [AW-1:0] ONE = AW'(1);

  state_t            state, state_next;
  esc_phase_t        esc, esc_next;
  logic [AW-1:0]     fill, fill_next;
  logic [AW-1:0]     len, len_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [BYTE_W-1:0] echo_byte, echo_byte_next;
  logic              slot_free;
  logic              load;
  logic              load_kind, load_last;
  logic [BYTE_W-1:0] load_byte;
  logic              accept;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign raddr     = ptr;
  assign waddr     = fill;

  always_comb begin
    state_next     = state;
    esc_next       = esc;
    fill_next      = fill;
    len_next       = len;
    ptr_next       = ptr;
    echo_byte_next = echo_byte;
    wr.we          = 1'b0;
    wr.data        = in_byte;
    load           = 1'b0;
    load_kind      = KIND_ECHO;
    load_byte      = CH_NUL;
    load_last      = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_byte == CH_ESC) begin
            esc_next = ESC_SEEN;
          end else if (in_byte == CH_BS || in_byte == CH_DEL) begin
            esc_next = ESC_IDLE;
            if (fill != '0) begin
              fill_next = fill - ONE;
              if (len == fill) begin
                len_next = fill - ONE;
              end
              state_next = S_BS1;
            end
          end else if (in_byte == CH_LF || in_byte == CH_CR) begin
            esc_next = ESC_IDLE;
            ptr_next = '0;
            if (len != '0) begin
              state_next = echo_enable ? S_LF : S_FETCH;
            end else begin
              fill_next = '0;
            end
          end else if (esc == ESC_SEEN && in_byte == CH_LBRACKET) begin
            esc_next = ESC_BRACKET;
          end else if (esc == ESC_BRACKET && (in_byte inside {CH_UP, CH_DOWN})) begin
            esc_next = ESC_IDLE;
          end else begin
            esc_next = ESC_IDLE;
            if (fill < FILL_MAX) begin
              wr.we     = 1'b1;
              fill_next = fill + ONE;
              if (len == fill && in_byte != CH_NUL) begin
                len_next = fill + ONE;
              end
              echo_byte_next = in_byte;
              if (echo_enable) begin
                state_next = S_ECHO;
              end
            end
          end
        end
      end
      S_BS1: begin
        if (slot_free) begin
          load = 1'b1; load_byte = CH_BS; state_next = S_BS2;
        end
      end
      S_BS2: begin
        if (slot_free) begin
          load = 1'b1; load_byte = CH_SPACE; state_next = S_BS3;
        end
      end
      S_BS3: begin
        if (slot_free) begin
          load = 1'b1; load_byte = CH_BS; load_last = 1'b1; state_next = S_IDLE;
        end
      end
      S_LF: begin
        if (slot_free) begin
          load = 1'b1; load_byte = CH_LF; state_next = S_CR;
        end
      end
      S_CR: begin
        if (slot_free) begin
          load = 1'b1; load_byte = CH_CR; state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (slot_free) begin
          load      = 1'b1;
          load_kind = KIND_LINE;
          load_byte = rd_data;
          load_last = (ptr == len - ONE);
          if (load_last) begin
            fill_next  = '0;
            len_next   = '0;
            state_next = S_IDLE;
          end else begin
            ptr_next   = ptr + ONE;
            state_next = S_FETCH;
          end
        end
      end
      S_ECHO: begin
        if (slot_free) begin
          load = 1'b1; load_byte = echo_byte; load_last = 1'b1; state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      esc       <= ESC_IDLE;
      fill      <= '0;
      len       <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      esc   <= esc_next;
      fill  <= fill_next;
      len   <= len_next;
      ptr   <= ptr_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    echo_byte <= echo_byte_next;
    if (load) begin
      out_kind <= load_kind;
      out_byte <= load_byte;
      out_last <= load_last;
    end
  end

endmodule

/* hdl/serial_command_line_editor_unit.sv */
// Channel   | Dir | Beat payload                      | Accepted when
// in_ch     | in  | rx_byte                           | valid && ready
// out_ch    | out | out_kind, out_byte, run_last      | valid && ready
// cfg       | in  | cfg_wdata (echo_enable)           | cfg_we
// One received byte at a time; ready is high only while the sequencer is idle.
// An echoed byte is accepted, then sent as an echo beat; an erase sends BS, space, BS.
// Enter sends LF, CR if echo is on, then each line byte in fetch and send states, set by
// the store's registered read port. Output stalls hold the sequencer; rst is synchronous
// and clears the counters, escape tracker and output valid; echo_enable resets to 1.
// Depends on slce_pkg, slce_chan_if, slce_line_store and slce_ctrl.
module serial_command_line_editor_unit #(
  parameter int LINE_CAPACITY = slce_pkg::LINE_CAPACITY_DEF
) (
  input logic    clk,
  input logic    rst,
  input logic    cfg_we,
  input logic    cfg_wdata,
  slce_rx_if.sink   in_ch,
  slce_tx_if.source out_ch
);
  import slce_pkg::*;

  localparam int AW = $clog2(LINE_CAPACITY);

  logic              echo_enable;
  store_wr_t         wr;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [BYTE_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b1;
    end else if (cfg_we) begin
      echo_enable <= cfg_wdata;
    end
  end

  slce_line_store #(.LINE_CAPACITY(LINE_CAPACITY)) u_store (
    .clk     (clk),
    .wr      (wr),
    .waddr   (waddr),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

  slce_ctrl #(.LINE_CAPACITY(LINE_CAPACITY)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .echo_enable (echo_enable),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_byte     (in_ch.rx_byte),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.out_kind),
    .out_byte    (out_ch.out_byte),
    .out_last    (out_ch.run_last),
    .wr          (wr),
    .waddr       (waddr),
    .raddr       (raddr),
    .rd_data     (rd_data)
  );

endmodule

/* hdl/slce_checker.sv */
// Port-level checks for serial_command_line_editor_unit, attached by bind.
// Depends on slce_pkg.
module slce_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [slce_pkg::BYTE_W-1:0] out_byte,
  input logic                        run_last
);
  import slce_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  a_busy_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> !in_ready || (out_valid && run_last))
    else $error("input ready in the middle of a run");

  a_line_fetch_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_kind == KIND_LINE && !run_last
      && !$past(out_valid && !out_ready) |=> !out_valid)
    else $error("line beat without a fetch cycle");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
      && $stable(run_last))
    else $error("stalled beat changed");

endmodule

bind serial_command_line_editor_unit slce_checker u_slce_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.out_kind),
  .out_byte  (out_ch.out_byte),
  .run_last  (out_ch.run_last)
);
